### design/msas_pkg.sv
// Package for the multichannel sensor average scaler.
// Holds shared constants, register codes, state enums and the config struct.
package msas_pkg;

    localparam int CHANNEL_COUNT = 5;
    localparam int SAMPLE_W      = 12;
    localparam int MV_W          = 25;
    localparam int DIV_W         = 36;
    localparam int DVS_W         = 12;
    localparam int RES_W         = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 13;

    localparam int CH_SOLAR    = 0;
    localparam int CH_BATTERY  = 1;
    localparam int CH_IIN      = 2;
    localparam int CH_IOUT     = 3;
    localparam int CH_SUPERCAP = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VREF        = 3'd0,
        REG_FULL_SCALE  = 3'd1,
        REG_DIV_RATIO   = 3'd2,
        REG_CUR_OFFSET  = 3'd3,
        REG_SENSITIVITY = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [12:0] vref_millivolts;
        logic [11:0] adc_full_scale;
        logic [10:0] divider_ratio_x100;
        logic [12:0] current_offset_mv;
        logic [9:0]  current_sensitivity;
    } cfg_t;

    typedef enum logic {
        F_IDLE,
        F_UPDATE
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_AVG,
        B_MUL1,
        B_DIV1_GO,
        B_DIV1_WAIT,
        B_MUL2,
        B_DIV2_GO,
        B_DIV2_WAIT,
        B_OUT
    } back_state_t;

endpackage

### design/msas_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on msas_pkg for operand widths.
module msas_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [msas_pkg::DIV_W-1:0]    dividend,
    input  logic [msas_pkg::DVS_W-1:0]    divisor,
    output logic [msas_pkg::DIV_W-1:0]    quotient,
    output logic                          done
);
    localparam int CNT_W = $clog2(msas_pkg::DIV_W + 1);

    logic [msas_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [msas_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [msas_pkg::DVS_W-1:0] den_reg;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [msas_pkg::DVS_W:0]   trial;
    logic [msas_pkg::DVS_W:0]   diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[msas_pkg::DIV_W-1]};
        diff      = trial - {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(msas_pkg::DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = diff[msas_pkg::DVS_W-1:0];
                quo_next = {quo_reg[msas_pkg::DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[msas_pkg::DVS_W-1:0];
                quo_next = {quo_reg[msas_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (start) begin
            den_reg <= divisor;
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

### design/msas_queue.sv
// Two-entry queue between the front and back parts.
// Standalone; width set by the instantiating module.
module msas_queue #(
    parameter int WIDTH = 90
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             not_empty
);
    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    assign pop_data  = entry_reg[rd_ptr_reg];
    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);

endmodule

### design/msas_front.sv
// Front part: accepts scans, keeps the sample rings and running sums.
// Depends on msas_pkg; pushes the five channel sums into the queue.
module msas_front #(
    parameter int WINDOW_LENGTH = 8,
    parameter int SUM_W         = 15
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic [msas_pkg::SAMPLE_W-1:0]             s_raw_solar_volt,
    input  logic [msas_pkg::SAMPLE_W-1:0]             s_raw_battery_volt,
    input  logic [msas_pkg::SAMPLE_W-1:0]             s_raw_input_current,
    input  logic [msas_pkg::SAMPLE_W-1:0]             s_raw_output_current,
    input  logic [msas_pkg::SAMPLE_W-1:0]             s_raw_supercap_volt,
    input  logic                                      q_full,
    output logic                                      q_push,
    output logic [msas_pkg::CHANNEL_COUNT*SUM_W-1:0]  q_data
);
    localparam int PTR_W = $clog2(WINDOW_LENGTH);
    localparam int ROW_W = msas_pkg::CHANNEL_COUNT * msas_pkg::SAMPLE_W;

    msas_pkg::front_state_t state_reg, state_next;

    logic [ROW_W-1:0]         hist_mem [WINDOW_LENGTH];
    logic [WINDOW_LENGTH-1:0] valid_reg;
    logic [ROW_W-1:0]         rd_row_reg;
    logic [ROW_W-1:0]         samp_reg;
    logic [PTR_W-1:0]         ptr_reg;
    logic [SUM_W-1:0]         sum_reg [msas_pkg::CHANNEL_COUNT];
    logic [SUM_W-1:0]         sum_next [msas_pkg::CHANNEL_COUNT];
    logic [ROW_W-1:0]         old_row;
    logic                     accept;

    assign accept = s_valid && s_ready;
    assign old_row = valid_reg[ptr_reg] ? rd_row_reg : '0;

    always_comb begin
        for (int c = 0; c < msas_pkg::CHANNEL_COUNT; c++) begin
            sum_next[c] = sum_reg[c]
                - SUM_W'(old_row[c*msas_pkg::SAMPLE_W +: msas_pkg::SAMPLE_W])
                + SUM_W'(samp_reg[c*msas_pkg::SAMPLE_W +: msas_pkg::SAMPLE_W]);
            q_data[c*SUM_W +: SUM_W] = sum_next[c];
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        q_push     = 1'b0;
        unique case (state_reg)
            msas_pkg::F_IDLE: begin
                s_ready = !q_full;
                if (s_valid && !q_full) begin
                    state_next = msas_pkg::F_UPDATE;
                end
            end
            msas_pkg::F_UPDATE: begin
                q_push     = 1'b1;
                state_next = msas_pkg::F_IDLE;
            end
            default: state_next = msas_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= msas_pkg::F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_row_reg <= hist_mem[ptr_reg];
            samp_reg   <= {s_raw_supercap_volt, s_raw_output_current, s_raw_input_current,
                           s_raw_battery_volt, s_raw_solar_volt};
        end
        if (q_push) begin
            hist_mem[ptr_reg] <= samp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            ptr_reg   <= '0;
            for (int c = 0; c < msas_pkg::CHANNEL_COUNT; c++) begin
                sum_reg[c] <= '0;
            end
        end else if (q_push) begin
            valid_reg[ptr_reg] <= 1'b1;
            ptr_reg <= (ptr_reg == PTR_W'(WINDOW_LENGTH - 1)) ? '0 : ptr_reg + 1'b1;
            for (int c = 0; c < msas_pkg::CHANNEL_COUNT; c++) begin
                sum_reg[c] <= sum_next[c];
            end
        end
    end

endmodule

### design/msas_back.sv
// Back part: averages each channel by reciprocal multiply and scales it through the shared divider.
// Depends on msas_pkg and msas_divider; drives the result register.
module msas_back #(
    parameter int WINDOW_LENGTH = 8,
    parameter int SUM_W         = 15
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  msas_pkg::cfg_t                            cfg,
    input  logic                                      q_not_empty,
    input  logic [msas_pkg::CHANNEL_COUNT*SUM_W-1:0]  q_data,
    output logic                                      q_pop,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic [msas_pkg::RES_W-1:0]                m_solar_millivolts,
    output logic [msas_pkg::RES_W-1:0]                m_battery_millivolts,
    output logic [msas_pkg::RES_W-1:0]                m_supercap_millivolts,
    output logic signed [msas_pkg::RES_W-1:0]         m_input_milliamps,
    output logic signed [msas_pkg::RES_W-1:0]         m_output_milliamps
);
    localparam int DW = msas_pkg::DIV_W;
    localparam int MW = msas_pkg::MV_W;
    localparam int AP_W   = 2 * SUM_W + 1;
    localparam int AVG_SH = SUM_W + $clog2(WINDOW_LENGTH);
    localparam longint AVG_RCP = ((longint'(1) << AVG_SH) + longint'(WINDOW_LENGTH) - 1)
                               / longint'(WINDOW_LENGTH);
    localparam int RCP100_SH = 30;
    localparam longint RCP100 = ((longint'(1) << RCP100_SH) + 99) / 100;
    localparam int VP_W = 47;
    localparam longint VSAT_LIMIT = 65536 * 100;

    msas_pkg::back_state_t state_reg, state_next;

    logic [msas_pkg::CHANNEL_COUNT*SUM_W-1:0] sums_reg;
    logic [2:0]                       ch_reg;
    logic [msas_pkg::SAMPLE_W-1:0]    avg_reg;
    logic [MW-1:0]                    mv_reg;
    logic [DW-1:0]                    prod_reg;
    logic                             neg_reg;
    logic [msas_pkg::RES_W-1:0]       res_reg [msas_pkg::CHANNEL_COUNT];
    logic                             m_valid_reg;
    logic [msas_pkg::RES_W-1:0]       out_reg [msas_pkg::CHANNEL_COUNT];

    logic                             div_start;
    logic [DW-1:0]                    div_dividend;
    logic [msas_pkg::DVS_W-1:0]       div_divisor;
    logic [DW-1:0]                    quo;
    logic                             div_done;
    logic                             is_current;
    logic                             last_ch;
    logic signed [MW:0]               delta;
    logic [MW-1:0]                    mag;
    logic [msas_pkg::RES_W-1:0]       sat_val;
    logic [msas_pkg::RES_W-1:0]       vsat_val;
    logic [AP_W-1:0]                  avg_prod;
    logic [VP_W-1:0]                  vprod;
    logic                             load_out;
    logic                             store_res;

    assign is_current = (ch_reg == 3'(msas_pkg::CH_IIN)) || (ch_reg == 3'(msas_pkg::CH_IOUT));
    assign last_ch    = (ch_reg == 3'(msas_pkg::CHANNEL_COUNT - 1));
    assign delta = $signed({1'b0, mv_reg}) - $signed((MW+1)'(cfg.current_offset_mv));
    assign mag   = delta[MW] ? MW'(-delta) : delta[MW-1:0];

    assign avg_prod = AP_W'(sums_reg[ch_reg*SUM_W +: SUM_W]) * AP_W'(AVG_RCP);
    assign vprod    = VP_W'(prod_reg[22:0]) * VP_W'(RCP100);
    assign vsat_val = (prod_reg >= DW'(VSAT_LIMIT)) ? 16'hFFFF : vprod[RCP100_SH +: 16];

    always_comb begin
        if (!neg_reg) begin
            sat_val = (|quo[DW-1:15]) ? 16'h7FFF : quo[15:0];
        end else if ((|quo[DW-1:16]) || (quo[15] && (|quo[14:0]))) begin
            sat_val = 16'h8000;
        end else begin
            sat_val = 16'(-quo[15:0]);
        end
    end

    assign div_dividend = prod_reg;

    always_comb begin
        if (state_reg == msas_pkg::B_DIV1_GO) begin
            div_divisor = (cfg.adc_full_scale == '0) ? 12'd1 : cfg.adc_full_scale;
        end else begin
            div_divisor = (cfg.current_sensitivity == '0) ? 12'd1
                        : 12'(cfg.current_sensitivity);
        end
    end

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        q_pop      = 1'b0;
        load_out   = 1'b0;
        store_res  = 1'b0;
        unique case (state_reg)
            msas_pkg::B_IDLE: begin
                if (q_not_empty) begin
                    q_pop      = 1'b1;
                    state_next = msas_pkg::B_AVG;
                end
            end
            msas_pkg::B_AVG: state_next = msas_pkg::B_MUL1;
            msas_pkg::B_MUL1: state_next = msas_pkg::B_DIV1_GO;
            msas_pkg::B_DIV1_GO: begin
                div_start  = 1'b1;
                state_next = msas_pkg::B_DIV1_WAIT;
            end
            msas_pkg::B_DIV1_WAIT: begin
                if (div_done) state_next = msas_pkg::B_MUL2;
            end
            msas_pkg::B_MUL2: state_next = msas_pkg::B_DIV2_GO;
            msas_pkg::B_DIV2_GO: begin
                if (is_current) begin
                    div_start  = 1'b1;
                    state_next = msas_pkg::B_DIV2_WAIT;
                end else begin
                    store_res  = 1'b1;
                    state_next = last_ch ? msas_pkg::B_OUT : msas_pkg::B_AVG;
                end
            end
            msas_pkg::B_DIV2_WAIT: begin
                if (div_done) begin
                    store_res  = 1'b1;
                    state_next = last_ch ? msas_pkg::B_OUT : msas_pkg::B_AVG;
                end
            end
            msas_pkg::B_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = msas_pkg::B_IDLE;
                end
            end
            default: state_next = msas_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= msas_pkg::B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            sums_reg <= q_data;
            ch_reg   <= '0;
        end
        if (state_reg == msas_pkg::B_AVG) begin
            avg_reg <= avg_prod[AVG_SH +: msas_pkg::SAMPLE_W];
        end
        if (state_reg == msas_pkg::B_MUL1) begin
            prod_reg <= DW'(MW'(avg_reg) * MW'(cfg.vref_millivolts));
        end
        if (state_reg == msas_pkg::B_DIV1_WAIT && div_done) begin
            mv_reg <= quo[MW-1:0];
        end
        if (state_reg == msas_pkg::B_MUL2) begin
            if (is_current) begin
                prod_reg <= DW'(mag) * DW'(10'd1000);
                neg_reg  <= delta[MW];
            end else begin
                prod_reg <= DW'(mv_reg) * DW'(cfg.divider_ratio_x100);
                neg_reg  <= 1'b0;
            end
        end
        if (store_res) begin
            res_reg[ch_reg] <= is_current ? sat_val : vsat_val;
            ch_reg          <= ch_reg + 3'd1;
        end
        if (load_out) begin
            for (int c = 0; c < msas_pkg::CHANNEL_COUNT; c++) begin
                out_reg[c] <= res_reg[c];
            end
        end
    end

    msas_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quo),
        .done     (div_done)
    );

    assign m_valid               = m_valid_reg;
    assign m_solar_millivolts    = out_reg[msas_pkg::CH_SOLAR];
    assign m_battery_millivolts  = out_reg[msas_pkg::CH_BATTERY];
    assign m_supercap_millivolts = out_reg[msas_pkg::CH_SUPERCAP];
    assign m_input_milliamps     = out_reg[msas_pkg::CH_IIN];
    assign m_output_milliamps    = out_reg[msas_pkg::CH_IOUT];

endmodule

### design/multichannel_sensor_average_scaler.sv
// Multichannel sensor average scaler, top level.
// Depends on msas_pkg, msas_front, msas_queue and msas_back.
//
// Input channel (s_valid/s_ready): one scan of five 12-bit raw ADC codes.
// Each code enters its channel's ring of the last WINDOW_LENGTH samples.
// Result channel (m_valid/m_ready): solar, battery and supercap voltage in
// mV (unsigned, saturated) and input and output current in mA (signed,
// saturated), from the ring averages.
// Configuration: cfg_wr_en, cfg_index, cfg_wr_data; write only while idle.
// Averages and the voltage divide by 100 use reciprocal multiplies; the
// full-scale divide (all channels) and the sensitivity divide (current
// channels) run on one shared restoring divider. The five channels run one
// after another, and the back part takes the next scan from the queue only
// once the result of the last one is loaded.
// Reset clears the rings (per-slot valid bits), the sums and the ring
// pointer, and loads the default register values.
// A stalled receiver holds the result; the front accepts up to two more
// scans into its queue before s_ready drops.
module multichannel_sensor_average_scaler #(
    parameter int WINDOW_LENGTH = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [msas_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [msas_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [msas_pkg::SAMPLE_W-1:0]         s_raw_solar_volt,
    input  logic [msas_pkg::SAMPLE_W-1:0]         s_raw_battery_volt,
    input  logic [msas_pkg::SAMPLE_W-1:0]         s_raw_input_current,
    input  logic [msas_pkg::SAMPLE_W-1:0]         s_raw_output_current,
    input  logic [msas_pkg::SAMPLE_W-1:0]         s_raw_supercap_volt,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [msas_pkg::RES_W-1:0]            m_solar_millivolts,
    output logic [msas_pkg::RES_W-1:0]            m_battery_millivolts,
    output logic [msas_pkg::RES_W-1:0]            m_supercap_millivolts,
    output logic signed [msas_pkg::RES_W-1:0]     m_input_milliamps,
    output logic signed [msas_pkg::RES_W-1:0]     m_output_milliamps
);
    localparam int SUM_W = msas_pkg::SAMPLE_W + $clog2(WINDOW_LENGTH);
    localparam int Q_W   = msas_pkg::CHANNEL_COUNT * SUM_W;

    msas_pkg::cfg_t cfg_reg;
    logic           q_push, q_pop, q_full, q_not_empty;
    logic [Q_W-1:0] q_push_data, q_pop_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.vref_millivolts     <= 13'd3300;
            cfg_reg.adc_full_scale      <= 12'd4095;
            cfg_reg.divider_ratio_x100  <= 11'd1000;
            cfg_reg.current_offset_mv   <= 13'd2500;
            cfg_reg.current_sensitivity <= 10'd185;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                msas_pkg::REG_VREF:        cfg_reg.vref_millivolts <= cfg_wr_data;
                msas_pkg::REG_FULL_SCALE:  cfg_reg.adc_full_scale <= cfg_wr_data[11:0];
                msas_pkg::REG_DIV_RATIO:   cfg_reg.divider_ratio_x100 <= cfg_wr_data[10:0];
                msas_pkg::REG_CUR_OFFSET:  cfg_reg.current_offset_mv <= cfg_wr_data;
                msas_pkg::REG_SENSITIVITY: cfg_reg.current_sensitivity <= cfg_wr_data[9:0];
                default: ;
            endcase
        end
    end

    msas_front #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SUM_W         (SUM_W)
    ) u_front (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_raw_solar_volt     (s_raw_solar_volt),
        .s_raw_battery_volt   (s_raw_battery_volt),
        .s_raw_input_current  (s_raw_input_current),
        .s_raw_output_current (s_raw_output_current),
        .s_raw_supercap_volt  (s_raw_supercap_volt),
        .q_full               (q_full),
        .q_push               (q_push),
        .q_data               (q_push_data)
    );

    msas_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    msas_back #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SUM_W         (SUM_W)
    ) u_back (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg                   (cfg_reg),
        .q_not_empty           (q_not_empty),
        .q_data                (q_pop_data),
        .q_pop                 (q_pop),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_solar_millivolts    (m_solar_millivolts),
        .m_battery_millivolts  (m_battery_millivolts),
        .m_supercap_millivolts (m_supercap_millivolts),
        .m_input_milliamps     (m_input_milliamps),
        .m_output_milliamps    (m_output_milliamps)
    );

`ifndef NO_ASSERTIONS
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_not_empty) else $error("queue popped while empty");
    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full) else $error("queue pushed while full");
    a_accept_then_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> q_push) else $error("accepted scan not pushed");
    a_reset_no_result: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid) else $error("result valid right after reset");
`endif

endmodule

### verif/multichannel_sensor_average_scaler_tb.sv
// Testbench for multichannel_sensor_average_scaler: drives ADC scans, predicts
// the averaged and scaled readings in place and checks every result word.
// Depends on msas_pkg and the RTL of the block only.
module multichannel_sensor_average_scaler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW     = 8;
    localparam int CYCLE_CAP  = 20_000_000;
    localparam int NCH        = msas_pkg::CHANNEL_COUNT;

    typedef struct packed {
        logic [15:0]        solar_mv;
        logic [15:0]        battery_mv;
        logic [15:0]        supercap_mv;
        logic signed [15:0] iin_ma;
        logic signed [15:0] iout_ma;
    } reading_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [msas_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [msas_pkg::CFG_DATA_W-1:0] cfg_wr_data;
    logic                            s_valid;
    logic                            s_ready;
    logic [msas_pkg::SAMPLE_W-1:0]   s_raw_solar_volt;
    logic [msas_pkg::SAMPLE_W-1:0]   s_raw_battery_volt;
    logic [msas_pkg::SAMPLE_W-1:0]   s_raw_input_current;
    logic [msas_pkg::SAMPLE_W-1:0]   s_raw_output_current;
    logic [msas_pkg::SAMPLE_W-1:0]   s_raw_supercap_volt;
    logic                            m_valid;
    logic                            m_ready;
    logic [msas_pkg::RES_W-1:0]      m_solar_millivolts;
    logic [msas_pkg::RES_W-1:0]      m_battery_millivolts;
    logic [msas_pkg::RES_W-1:0]      m_supercap_millivolts;
    logic signed [msas_pkg::RES_W-1:0] m_input_milliamps;
    logic signed [msas_pkg::RES_W-1:0] m_output_milliamps;

    multichannel_sensor_average_scaler #(.WINDOW_LENGTH(WINDOW)) u_top (.*);

    // predictor state
    logic [12:0] vref_mv;
    logic [11:0] full_scale;
    logic [10:0] ratio_x100;
    logic [12:0] offset_mv;
    logic [9:0]  sens_mv_per_a;
    logic [11:0] ring [NCH][WINDOW];
    longint      ring_sum [NCH];
    int          ring_slot;

    reading_t    pending_readings[$];
    int          mismatches;
    longint      cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint channel_mv(int ch);
        longint fs;
        fs = (full_scale == 0) ? 1 : longint'(full_scale);
        return ((ring_sum[ch] / WINDOW) * longint'(vref_mv)) / fs;
    endfunction

    function automatic logic [15:0] volt_reading(int ch);
        longint v;
        v = (channel_mv(ch) * longint'(ratio_x100)) / 100;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    function automatic logic [15:0] amp_reading(int ch);
        longint ma;
        longint sens;
        sens = (sens_mv_per_a == 0) ? 1 : longint'(sens_mv_per_a);
        ma = ((channel_mv(ch) - longint'(offset_mv)) * 1000) / sens;
        if (ma > 32767) ma = 32767;
        if (ma < -32768) ma = -32768;
        return ma[15:0];
    endfunction

    function automatic reading_t predict_scan(logic [11:0] raw [NCH]);
        reading_t r;
        for (int ch = 0; ch < NCH; ch++) begin
            ring_sum[ch] = ring_sum[ch] - ring[ch][ring_slot] + raw[ch];
            ring[ch][ring_slot] = raw[ch];
        end
        ring_slot = (ring_slot + 1) % WINDOW;
        r.solar_mv    = volt_reading(msas_pkg::CH_SOLAR);
        r.battery_mv  = volt_reading(msas_pkg::CH_BATTERY);
        r.supercap_mv = volt_reading(msas_pkg::CH_SUPERCAP);
        r.iin_ma      = amp_reading(msas_pkg::CH_IIN);
        r.iout_ma     = amp_reading(msas_pkg::CH_IOUT);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // result checker
    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_readings.size() == 0) begin
                report_mismatch("unexpected word", m_solar_millivolts, -1);
            end else begin
                want = pending_readings.pop_front();
                if (m_solar_millivolts !== want.solar_mv)
                    report_mismatch("solar_mv", m_solar_millivolts, want.solar_mv);
                if (m_battery_millivolts !== want.battery_mv)
                    report_mismatch("battery_mv", m_battery_millivolts, want.battery_mv);
                if (m_supercap_millivolts !== want.supercap_mv)
                    report_mismatch("supercap_mv", m_supercap_millivolts, want.supercap_mv);
                if (m_input_milliamps !== want.iin_ma)
                    report_mismatch("input_ma", m_input_milliamps, want.iin_ma);
                if (m_output_milliamps !== want.iout_ma)
                    report_mismatch("output_ma", m_output_milliamps, want.iout_ma);
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_scan(logic [11:0] raw [NCH]);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid              <= 1'b1;
        s_raw_solar_volt     <= raw[msas_pkg::CH_SOLAR];
        s_raw_battery_volt   <= raw[msas_pkg::CH_BATTERY];
        s_raw_input_current  <= raw[msas_pkg::CH_IIN];
        s_raw_output_current <= raw[msas_pkg::CH_IOUT];
        s_raw_supercap_volt  <= raw[msas_pkg::CH_SUPERCAP];
        do @(posedge aclk); while (!s_ready);
        pending_readings.push_back(predict_scan(raw));
    endtask

    task automatic send_flat(logic [11:0] v);
        logic [11:0] raw [NCH];
        foreach (raw[i]) raw[i] = v;
        send_scan(raw);
    endtask

    task automatic send_random_scan();
        logic [11:0] raw [NCH];
        foreach (raw[i]) begin
            case ($urandom_range(7))
                0:       raw[i] = 12'h000;
                1:       raw[i] = 12'hFFF;
                2:       raw[i] = 12'($urandom_range(15));
                default: raw[i] = 12'($urandom_range(4095));
            endcase
        end
        send_scan(raw);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic apply_config(logic [12:0] v0, logic [12:0] v1, logic [12:0] v2,
                                logic [12:0] v3, logic [12:0] v4);
        logic [12:0]        vals [NCH];
        msas_pkg::cfg_reg_t idx;
        vals = '{v0, v1, v2, v3, v4};
        for (int i = 0; i < NCH; i++) begin
            idx = msas_pkg::cfg_reg_t'(i);
            cfg_wr_en   <= 1'b1;
            cfg_index   <= idx;
            cfg_wr_data <= vals[i];
            case (idx)
                msas_pkg::REG_VREF:        vref_mv       = vals[i];
                msas_pkg::REG_FULL_SCALE:  full_scale    = vals[i][11:0];
                msas_pkg::REG_DIV_RATIO:   ratio_x100    = vals[i][10:0];
                msas_pkg::REG_CUR_OFFSET:  offset_mv     = vals[i];
                msas_pkg::REG_SENSITIVITY: sens_mv_per_a = vals[i][9:0];
                default: ;
            endcase
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_defaults_and_ring_fill();
        logic [11:0] raw [NCH];
        send_flat(12'h000);
        for (int i = 0; i < 8; i++) send_flat(12'hFFF);
        send_flat(12'hAAA);
        send_flat(12'h555);
        raw = '{12'h001, 12'h800, 12'hFFF, 12'h000, 12'h7FF};
        send_scan(raw);
        wait_idle();
    endtask

    task automatic test_config_extremes();
        // saturate high: big reference, tiny full scale and sensitivity
        apply_config(13'd5000, 13'd1, 13'd2000, 13'd0, 13'd1);
        for (int i = 0; i < 4; i++) send_flat(12'hFFF);
        send_flat(12'h001);
        wait_idle();
        // drive currents negative, zero divisors
        apply_config(13'd1, 13'd0, 13'd100, 13'd5000, 13'd0);
        for (int i = 0; i < 4; i++) send_flat(12'h000);
        send_flat(12'hFFF);
        wait_idle();
        apply_config(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
        for (int i = 0; i < 4; i++) send_random_scan();
        wait_idle();
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 150 == 0) begin
                wait_idle();
                if ($urandom_range(3) == 0)
                    apply_config(13'd3300, 13'd4095, 13'd1000, 13'd2500, 13'd185);
                else
                    apply_config(13'($urandom_range(8191)), 13'($urandom_range(4095)),
                                 13'($urandom_range(100, 2047)), 13'($urandom_range(8191)),
                                 13'($urandom_range(1023)));
            end
            send_random_scan();
        end
        wait_idle();
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_raw_solar_volt = '0;
        s_raw_battery_volt = '0;
        s_raw_input_current = '0;
        s_raw_output_current = '0;
        s_raw_supercap_volt = '0;
        m_ready = 1'b0;
        mismatches = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        vref_mv = 13'd3300;
        full_scale = 12'd4095;
        ratio_x100 = 11'd1000;
        offset_mv = 13'd2500;
        sens_mv_per_a = 10'd185;
        ring_slot = 0;
        foreach (ring_sum[c]) ring_sum[c] = 0;
        foreach (ring[c, k]) ring[c][k] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_defaults_and_ring_fill();
        test_config_extremes();
        test_random(600, 36, 59);
        test_random(600, 59, 36);
        test_random(600, 0, 0);

        repeat (700) @(posedge aclk);
        if (mismatches == 0 && pending_readings.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
